[hdl/dmc_pkg.sv]
// Shared types, constants and the rate table for the delta-modulation sample channel.
package dmc_pkg;

  // Request kinds carried by one input transfer
  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_ENABLE = 2'd2,
    REQ_SAMPLE = 2'd3
  } dmc_req_t;

  // Register numbers for a register write
  typedef enum logic [1:0] {
    REG_CTRL  = 2'd0,
    REG_LEVEL = 2'd1,
    REG_START = 2'd2,
    REG_LEN   = 2'd3
  } dmc_reg_t;

  localparam logic [15:0] ADDR_RESET    = 16'hC000;
  localparam logic [15:0] ADDR_WRAP     = 16'h8000;
  localparam logic [6:0]  LEVEL_UP_MAX  = 7'd125;
  localparam logic [6:0]  LEVEL_STEP    = 7'd2;
  localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

  // One accepted input item
  typedef struct packed {
    dmc_req_t    req_type;
    dmc_reg_t    reg_index;
    logic [7:0]  write_data;
    logic        enable_value;
    logic [7:0]  sample_byte;
  } dmc_item_t;

  // One result item
  typedef struct packed {
    logic [6:0]  level;
    logic        irq_flag;
    logic        fetch_request;
    logic [15:0] fetch_address;
    logic [11:0] bytes_left;
  } dmc_result_t;

  // Timer reload value for each rate index
  function automatic logic [8:0] rate_reload(input logic [3:0] idx);
    logic [8:0] r;
    unique case (idx)
      4'd0:    r = 9'd427;
      4'd1:    r = 9'd379;
      4'd2:    r = 9'd339;
      4'd3:    r = 9'd319;
      4'd4:    r = 9'd285;
      4'd5:    r = 9'd253;
      4'd6:    r = 9'd225;
      4'd7:    r = 9'd213;
      4'd8:    r = 9'd189;
      4'd9:    r = 9'd159;
      4'd10:   r = 9'd141;
      4'd11:   r = 9'd127;
      4'd12:   r = 9'd105;
      4'd13:   r = 9'd83;
      4'd14:   r = 9'd71;
      default: r = 9'd53;
    endcase
    return r;
  endfunction

endpackage

[hdl/dmc_ifs.sv]
// Valid/ready channel interfaces for the sample channel's input and result sides.
interface dmc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [1:0] reg_index;
  logic [7:0] write_data;
  logic       enable_value;
  logic [7:0] sample_byte;

  modport source (output valid, req_type, reg_index, write_data, enable_value,
                  sample_byte, input ready);
  modport sink   (input valid, req_type, reg_index, write_data, enable_value,
                  sample_byte, output ready);
endinterface

interface dmc_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  level;
  logic        irq_flag;
  logic        fetch_request;
  logic [15:0] fetch_address;
  logic [11:0] bytes_left;

  modport source (output valid, level, irq_flag, fetch_request, fetch_address,
                  bytes_left, input ready);
  modport sink   (input valid, level, irq_flag, fetch_request, fetch_address,
                  bytes_left, output ready);
endinterface

[hdl/dmc_engine.sv]
// Channel state registers and the single-pass update for one item.
module dmc_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  dmc_pkg::dmc_item_t   item,
  output dmc_pkg::dmc_result_t result
);
  import dmc_pkg::*;

  logic [3:0]  rate_index_r,  rate_index_nxt;
  logic        loop_mode_r,   loop_mode_nxt;
  logic        irq_en_r,      irq_en_nxt;
  logic        irq_pend_r,    irq_pend_nxt;
  logic [6:0]  level_r,       level_nxt;
  logic [15:0] start_addr_r,  start_addr_nxt;
  logic [11:0] sample_len_r,  sample_len_nxt;
  logic [15:0] cur_addr_r,    cur_addr_nxt;
  logic [11:0] remain_r,      remain_nxt;
  logic [8:0]  timer_r,       timer_nxt;
  logic [7:0]  shift_r,       shift_nxt;
  logic [3:0]  bits_left_r,   bits_left_nxt;
  logic        silent_r,      silent_nxt;
  logic [7:0]  buf_r,         buf_nxt;
  logic        buf_full_r,    buf_full_nxt;

  logic        fetch_go;
  logic        fetch_req;
  logic [15:0] fetch_addr;

  // Compute the next channel state for the current item
  always_comb begin
    rate_index_nxt = rate_index_r;
    loop_mode_nxt  = loop_mode_r;
    irq_en_nxt     = irq_en_r;
    irq_pend_nxt   = irq_pend_r;
    level_nxt      = level_r;
    start_addr_nxt = start_addr_r;
    sample_len_nxt = sample_len_r;
    cur_addr_nxt   = cur_addr_r;
    remain_nxt     = remain_r;
    timer_nxt      = timer_r;
    shift_nxt      = shift_r;
    bits_left_nxt  = bits_left_r;
    silent_nxt     = silent_r;
    buf_nxt        = buf_r;
    buf_full_nxt   = buf_full_r;
    fetch_go       = 1'b0;
    fetch_req      = 1'b0;
    fetch_addr     = '0;

    case (item.req_type)
      REQ_WRITE: begin
        unique case (item.reg_index)
          REG_CTRL: begin
            rate_index_nxt = item.write_data[3:0];
            loop_mode_nxt  = item.write_data[6];
            irq_en_nxt     = item.write_data[7];
            if (!item.write_data[7]) begin
              irq_pend_nxt = 1'b0;
            end
          end
          REG_LEVEL: level_nxt      = item.write_data[6:0];
          REG_START: start_addr_nxt = {2'b11, item.write_data, 6'b0};
          default:   sample_len_nxt = {item.write_data, 4'b0001};
        endcase
      end
      REQ_TICK: begin
        if (timer_r != '0) begin
          timer_nxt = timer_r - 9'd1;
        end else begin
          timer_nxt = rate_reload(rate_index_r);
          // Move the level unless it would leave the 7-bit range
          if (!silent_r) begin
            if (shift_r[0]) begin
              if (level_r <= LEVEL_UP_MAX) level_nxt = level_r + LEVEL_STEP;
            end else begin
              if (level_r >= LEVEL_STEP) level_nxt = level_r - LEVEL_STEP;
            end
          end
          shift_nxt     = {1'b0, shift_r[7:1]};
          bits_left_nxt = bits_left_r - 4'd1;
          // End of byte: reload from the buffer or go silent
          if (bits_left_nxt == '0) begin
            bits_left_nxt = BITS_PER_BYTE;
            if (buf_full_r) begin
              silent_nxt   = 1'b0;
              shift_nxt    = buf_r;
              buf_full_nxt = 1'b0;
              fetch_go     = 1'b1;
            end else begin
              silent_nxt = 1'b1;
            end
          end
        end
      end
      REQ_ENABLE: begin
        irq_pend_nxt = 1'b0;
        if (!item.enable_value) begin
          remain_nxt = '0;
        end else if (remain_r == '0) begin
          cur_addr_nxt = start_addr_r;
          remain_nxt   = sample_len_r;
          fetch_go     = !buf_full_r;
        end
      end
      default: begin
        buf_nxt      = item.sample_byte;
        buf_full_nxt = 1'b1;
      end
    endcase

    // Issue a fetch while bytes remain; advance address and count now
    if (fetch_go && remain_nxt != '0) begin
      fetch_req    = 1'b1;
      fetch_addr   = cur_addr_nxt;
      cur_addr_nxt = (cur_addr_nxt + 16'd1) | ADDR_WRAP;
      remain_nxt   = remain_nxt - 12'd1;
      if (remain_nxt == '0) begin
        if (loop_mode_nxt) begin
          cur_addr_nxt = start_addr_nxt;
          remain_nxt   = sample_len_nxt;
        end else if (irq_en_nxt) begin
          irq_pend_nxt = 1'b1;
        end
      end
    end
  end

  // Result reflects the state after this item
  always_comb begin
    result.level         = level_nxt;
    result.irq_flag      = irq_pend_nxt;
    result.fetch_request = fetch_req;
    result.fetch_address = fetch_addr;
    result.bytes_left    = remain_nxt;
  end

  // Commit state on each processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_index_r <= '0;
      loop_mode_r  <= 1'b0;
      irq_en_r     <= 1'b0;
      irq_pend_r   <= 1'b0;
      level_r      <= '0;
      start_addr_r <= ADDR_RESET;
      sample_len_r <= 12'd1;
      cur_addr_r   <= ADDR_RESET;
      remain_r     <= '0;
      timer_r      <= '0;
      shift_r      <= '0;
      bits_left_r  <= BITS_PER_BYTE;
      silent_r     <= 1'b1;
      buf_r        <= '0;
      buf_full_r   <= 1'b0;
    end else if (step) begin
      rate_index_r <= rate_index_nxt;
      loop_mode_r  <= loop_mode_nxt;
      irq_en_r     <= irq_en_nxt;
      irq_pend_r   <= irq_pend_nxt;
      level_r      <= level_nxt;
      start_addr_r <= start_addr_nxt;
      sample_len_r <= sample_len_nxt;
      cur_addr_r   <= cur_addr_nxt;
      remain_r     <= remain_nxt;
      timer_r      <= timer_nxt;
      shift_r      <= shift_nxt;
      bits_left_r  <= bits_left_nxt;
      silent_r     <= silent_nxt;
      buf_r        <= buf_nxt;
      buf_full_r   <= buf_full_nxt;
    end
  end

  // Bit counter always sits in 1..8
  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    bits_left_r != '0 && bits_left_r <= BITS_PER_BYTE)
    else $error("bit counter out of range");

  // Timer never exceeds the longest reload
  a_timer_range: assert property (@(posedge clk) disable iff (!rst_n)
    timer_r <= 9'd427)
    else $error("rate timer out of range");

  // Fetches always target the upper half of the address space
  a_fetch_addr: assert property (@(posedge clk) disable iff (!rst_n)
    step && fetch_req |-> fetch_addr[15])
    else $error("fetch address below wrap base");

  // A fetch consumes one buffered byte slot or starts a sample
  a_fetch_cause: assert property (@(posedge clk) disable iff (!rst_n)
    step && fetch_req |-> item.req_type == REQ_TICK || item.req_type == REQ_ENABLE)
    else $error("fetch issued by wrong request kind");

endmodule

[hdl/delta_modulation_sample_channel_unit.sv]
// Top level of the delta-modulation sample channel: input register, engine, result register.
//
//  channel  dir  handshake     payload
//  in_chan  in   valid/ready   req_type, reg_index, write_data, enable_value, sample_byte
//  out_chan out  valid/ready   level, irq_flag, fetch_request, fetch_address, bytes_left
//
// One item per clock sustained while the result side is not stalled; each item passes from
// transfer in to result out through the input register, then the state update into the result register.
// Reset (rst_n low, synchronous) restores the channel state and empties both registers.
// A stalled result holds the pipe; an item waiting in the input register is kept until
// the result register frees, so nothing is lost or repeated.
module delta_modulation_sample_channel_unit (
  input  logic      clk,
  input  logic      rst_n,
  dmc_in_if.sink    in_chan,
  dmc_out_if.source out_chan
);
  import dmc_pkg::*;

  logic        in_valid_r;
  dmc_item_t   item_r;
  logic        out_valid_r;
  dmc_result_t out_r;
  dmc_result_t result;
  logic        advance;
  logic        step;
  logic        in_ready;

  // Move forward whenever the result register is free or being drained
  assign advance  = !out_valid_r || out_chan.ready;
  assign in_ready = !in_valid_r || advance;
  assign step     = in_valid_r && advance;
  assign in_chan.ready = in_ready;

  // Capture input transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      item_r.req_type     <= dmc_req_t'(in_chan.req_type);
      item_r.reg_index    <= dmc_reg_t'(in_chan.reg_index);
      item_r.write_data   <= in_chan.write_data;
      item_r.enable_value <= in_chan.enable_value;
      item_r.sample_byte  <= in_chan.sample_byte;
    end
  end

  dmc_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item_r),
    .result (result)
  );

  // Hold results until transferred out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= result;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.level         = out_r.level;
  assign out_chan.irq_flag      = out_r.irq_flag;
  assign out_chan.fetch_request = out_r.fetch_request;
  assign out_chan.fetch_address = out_r.fetch_address;
  assign out_chan.bytes_left    = out_r.bytes_left;

  // A waiting item is never dropped while the output stalls
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(item_r))
    else $error("stalled item lost");

  // An empty input register always takes a transfer
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_ready)
    else $error("input blocked while empty");

  // A processed item always produces a pending result
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("result missing after step");

endmodule
